FILE: design/negacyclic_poly_multiplier_defines.svh
// Assertion macros used by the negacyclic multiplier controller.
`ifndef NEGACYCLIC_POLY_MULTIPLIER_DEFINES_SVH
`define NEGACYCLIC_POLY_MULTIPLIER_DEFINES_SVH

// Checked property, suspended while reset is held.
`define NPM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("npm assertion failed");

// Checked property, also checked during reset.
`define NPM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("npm assertion failed");

`endif

FILE: design/npm_pkg.sv
package npm_pkg;

  // default polynomial degree
  localparam int DEGREE_DEF = 64;

  // field widths
  localparam int COEF_W     = 32;
  localparam int SEC_W      = 33;
  localparam int ACC_W      = 64;
  localparam int IDX_W      = 6;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 72;

  // commands from controller to datapath
  typedef struct packed {
    logic load;        // write operand word, shift second operand row
    logic sub;         // store second minus first
    logic issue;       // read one first-operand coefficient
    logic issue_first; // that read starts a new product
    logic out_shift;   // result word taken, shift accumulator row
  } ctrl_cmd_t;

endpackage

FILE: design/npm_ram.sv
module npm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/npm_ctrl.sv
`include "negacyclic_poly_multiplier_defines.svh"

module npm_ctrl
  import npm_pkg::*;
#(
  parameter int DEGREE = DEGREE_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_mode,
  output logic                      in_ready,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_last,
  output logic [IDX_W-1:0]          out_index,
  output ctrl_cmd_t                 cmd,
  output logic [$clog2(DEGREE)-1:0] load_addr,
  output logic [$clog2(DEGREE)-1:0] rd_addr
);

  localparam int ADDR_W = $clog2(DEGREE);
  localparam int CNT_W  = $clog2(DEGREE + 2);

  localparam logic [1:0] ST_LOAD    = 2'd0;
  localparam logic [1:0] ST_WAIT    = 2'd1;
  localparam logic [1:0] ST_COMPUTE = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [ADDR_W-1:0] load_cnt_r, load_cnt_nxt;
  logic             mode_r, mode_nxt;
  logic [CNT_W-1:0] step_r, step_nxt;
  logic             out_busy_r, out_busy_nxt;
  logic [IDX_W-1:0] out_cnt_r, out_cnt_nxt;

  logic in_acc;
  logic out_acc;
  logic mode_now;
  logic load_done;
  logic issue;

  // handshakes
  assign in_ready  = (state_r == ST_LOAD);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_busy_r;
  assign out_acc   = out_busy_r && out_ready;
  assign out_last  = (out_cnt_r == IDX_W'(DEGREE - 1));
  assign out_index = out_cnt_r;

  // mode is taken from the first word of a load
  assign mode_now  = (load_cnt_r == '0) ? in_mode : mode_r;
  assign load_done = in_acc && (load_cnt_r == ADDR_W'(DEGREE - 1));
  assign issue     = (state_r == ST_COMPUTE) && (step_r < CNT_W'(DEGREE));

  // datapath commands
  assign cmd.load        = in_acc;
  assign cmd.sub         = mode_now;
  assign cmd.issue       = issue;
  assign cmd.issue_first = issue && (step_r == '0);
  assign cmd.out_shift   = out_acc;
  assign load_addr       = load_cnt_r;
  assign rd_addr         = step_r[ADDR_W-1:0];

  // sequencing: load, wait for the result row to drain, multiply
  always_comb begin
    state_nxt    = state_r;
    load_cnt_nxt = load_cnt_r;
    mode_nxt     = mode_r;
    step_nxt     = step_r;
    out_busy_nxt = out_busy_r;
    out_cnt_nxt  = out_cnt_r;

    if (in_acc) begin
      mode_nxt     = mode_now;
      load_cnt_nxt = load_done ? '0 : load_cnt_r + 1'b1;
    end

    if (out_acc) begin
      if (out_last) begin
        out_busy_nxt = 1'b0;
        out_cnt_nxt  = '0;
      end else begin
        out_cnt_nxt = out_cnt_r + 1'b1;
      end
    end

    case (state_r)
      ST_LOAD: begin
        if (load_done) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (!out_busy_r) begin
          state_nxt = ST_COMPUTE;
          step_nxt  = '0;
        end
      end
      ST_COMPUTE: begin
        // after the last read, keep stepping while the multiply and accumulate registers finish
        if (step_r == CNT_W'(DEGREE + 1)) begin
          state_nxt    = ST_LOAD;
          out_busy_nxt = 1'b1;
          out_cnt_nxt  = '0;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      load_cnt_r <= '0;
      mode_r     <= 1'b0;
      step_r     <= '0;
      out_busy_r <= 1'b0;
      out_cnt_r  <= '0;
    end else begin
      state_r    <= state_nxt;
      load_cnt_r <= load_cnt_nxt;
      mode_r     <= mode_nxt;
      step_r     <= step_nxt;
      out_busy_r <= out_busy_nxt;
      out_cnt_r  <= out_cnt_nxt;
    end
  end

  // accumulators are never rewritten while results are still out
  `NPM_ASSERT(a_compute_idle_out, clk, rst_n, (state_r == ST_COMPUTE) |-> !out_busy_r)
  // a completed load stops intake until the product is formed
  `NPM_ASSERT(a_load_stops, clk, rst_n, load_done |=> !in_ready)
  // the last result word ends the burst
  `NPM_ASSERT(a_last_ends, clk, rst_n, (out_acc && out_last) |=> !out_valid)
  // reset clears the result index
  `NPM_ASSERT_ALWAYS(a_rst_quiet, clk, !rst_n |=> (out_cnt_r == '0))

endmodule

FILE: design/npm_datapath.sv
module npm_datapath
  import npm_pkg::*;
#(
  parameter int DEGREE = DEGREE_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ctrl_cmd_t                 cmd,
  input  logic [$clog2(DEGREE)-1:0] load_addr,
  input  logic [$clog2(DEGREE)-1:0] rd_addr,
  input  logic signed [COEF_W-1:0]  first_coef,
  input  logic signed [COEF_W-1:0]  second_coef,
  output logic signed [ACC_W-1:0]   result_coef
);

  logic signed [COEF_W-1:0] a_q;
  logic signed [SEC_W-1:0]  sec_val;
  logic signed [SEC_W-1:0]  sr_r [DEGREE];
  logic signed [ACC_W-1:0]  p_r [DEGREE];
  logic signed [ACC_W-1:0]  acc_r [DEGREE];
  logic v1_r, f1_r, v2_r, f2_r;

  // first operand store
  npm_ram #(
    .WIDTH (COEF_W),
    .DEPTH (DEGREE)
  ) u_first_ram (
    .clk   (clk),
    .we    (cmd.load),
    .waddr (load_addr),
    .wdata (first_coef),
    .re    (cmd.issue),
    .raddr (rd_addr),
    .rdata (a_q)
  );

  // second operand: second, or second minus first, as 33-bit value
  assign sec_val = cmd.sub
                 ? ({second_coef[COEF_W-1], second_coef} - {first_coef[COEF_W-1], first_coef})
                 : {second_coef[COEF_W-1], second_coef};

  // pipeline valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      f1_r <= 1'b0;
      v2_r <= 1'b0;
      f2_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      f1_r <= cmd.issue_first;
      v2_r <= v1_r;
      f2_r <= f1_r;
    end
  end

  // second operand row: shift in on load, negacyclic rotate per step
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int k = 0; k < DEGREE - 1; k++) begin
        sr_r[k] <= sr_r[k+1];
      end
      sr_r[DEGREE-1] <= sec_val;
    end else if (v1_r) begin
      sr_r[0] <= -sr_r[DEGREE-1];
      for (int k = 1; k < DEGREE; k++) begin
        sr_r[k] <= sr_r[k-1];
      end
    end
  end

  // one multiply-accumulate cell per result coefficient
  for (genvar k = 0; k < DEGREE; k++) begin : g_cell
    logic signed [COEF_W+SEC_W-1:0] prod;

    assign prod = a_q * sr_r[k];

    always_ff @(posedge clk) begin
      if (v1_r) begin
        p_r[k] <= prod[ACC_W-1:0];
      end
    end

    if (k < DEGREE - 1) begin : g_mid
      always_ff @(posedge clk) begin
        if (v2_r) begin
          acc_r[k] <= f2_r ? p_r[k] : acc_r[k] + p_r[k];
        end else if (cmd.out_shift) begin
          acc_r[k] <= acc_r[k+1];
        end
      end
    end else begin : g_end
      always_ff @(posedge clk) begin
        if (v2_r) begin
          acc_r[k] <= f2_r ? p_r[k] : acc_r[k] + p_r[k];
        end
      end
    end
  end

  assign result_coef = acc_r[0];

endmodule

FILE: design/negacyclic_poly_multiplier.sv
// channel | dir | tdata (low bit up)                     | tuser | tlast
// in_     | in  | first_coef[31:0], second_coef[63:32]   | mode  | -
// out_    | out | coef_index[5:0], result_coef[69:6], 0s | -     | last coef
//
// A load takes DEGREE words, one per cycle while in_tready is high.
// After a wait state the product is formed in a row of DEGREE
// multiply-accumulate cells, one first-operand coefficient read from RAM per cycle.
// DEGREE result words follow, one per cycle while out_tready is high; the next
// load runs alongside them; its product starts once the last result word is taken.
// out_tready low holds the result row; reset is synchronous, active low.
module negacyclic_poly_multiplier
  import npm_pkg::*;
#(
  parameter int DEGREE = DEGREE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // first_coef, second_coef
  input  logic                  in_tuser,   // mode
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // coef_index, result_coef, zero pad
  output logic                  out_tlast
);

  localparam int ADDR_W = $clog2(DEGREE);

  ctrl_cmd_t          cmd;
  logic [ADDR_W-1:0]  load_addr;
  logic [ADDR_W-1:0]  rd_addr;
  logic [IDX_W-1:0]   out_index;
  logic signed [ACC_W-1:0] result_coef;

  npm_ctrl #(
    .DEGREE (DEGREE)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_mode   (in_tuser),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_last  (out_tlast),
    .out_index (out_index),
    .cmd       (cmd),
    .load_addr (load_addr),
    .rd_addr   (rd_addr)
  );

  npm_datapath #(
    .DEGREE (DEGREE)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .load_addr   (load_addr),
    .rd_addr     (rd_addr),
    .first_coef  (in_tdata[COEF_W-1:0]),
    .second_coef (in_tdata[2*COEF_W-1:COEF_W]),
    .result_coef (result_coef)
  );

  // result word packing
  assign out_tdata = {{(OUT_DATA_W - ACC_W - IDX_W){1'b0}}, result_coef, out_index};

endmodule
